[rtl/ffs_pkg.sv]
`timescale 1ns / 1ps

package ffs_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 23;
   localparam int ALPHA_W   = 16;
   localparam int AGE_W     = 16;
   localparam int CORNER_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 23;

   // shared multiplier operands: 25-bit signed by 17-bit signed
   localparam int MUL_A_W = SAMPLE_W + 1;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_YAW_NEGATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FF_GAIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FF_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LPF_ALPHA     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

   localparam logic signed [GAIN_W-1:0]  GAIN_RESET    = 16'sd256;
   localparam logic [LIMIT_W-1:0]        LIMIT_RESET   = 23'd25600;
   localparam logic [ALPHA_W-1:0]        ALPHA_RESET   = 16'd52429;
   localparam logic [AGE_W-1:0]          TIMEOUT_RESET = 16'd100;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_TICK = 6'b000010,
      S_MUL1 = 6'b000100,
      S_RND  = 6'b001000,
      S_MUL2 = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

endpackage

[rtl/ffs_mul.sv]
`timescale 1ns / 1ps

module ffs_mul import ffs_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [MUL_A_W-1:0]  a,
   input  logic signed [MUL_B_W-1:0]  b,
   output logic signed [PROD_W-1:0]   prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/feedforward_filter_with_staleness_unit.sv]
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// req      req_valid / req_ready     operation, yaw_rate, speed_diff, corner_number
// rsp      rsp_valid / rsp_ready     fresh, yaw_rate_out, feedforward_out,
//                                    speed_diff_out, corner_out
// csr      csr_valid / csr_ready     csr_index, csr_wdata
//
// A tick word goes straight to its result step; a sample word first passes the
// MUL1, RND and MUL2 steps: the gain and alpha products go one after the other
// through one 25x17 multiplier. req_ready is high only in idle, so one word is in
// work at a time. A finished result waits in the output register; the next word
// is accepted meanwhile and stalls at its last step until that register is free.
// Reset (synchronous, active high) restores register defaults and clears state.

module feedforward_filter_with_staleness_unit import ffs_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic signed [SAMPLE_W-1:0]  req_yaw_rate,
   input  logic signed [SAMPLE_W-1:0]  req_speed_diff,
   input  logic [CORNER_W-1:0]         req_corner_number,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_fresh,
   output logic signed [SAMPLE_W-1:0]  rsp_yaw_rate_out,
   output logic signed [SAMPLE_W-1:0]  rsp_feedforward_out,
   output logic signed [SAMPLE_W-1:0]  rsp_speed_diff_out,
   output logic [CORNER_W-1:0]         rsp_corner_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DAT_W-1:0]        csr_wdata
);

   state_type state_ff, state_in;

   // configuration
   logic                       negate_ff;
   logic signed [GAIN_W-1:0]   gain_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   logic [ALPHA_W-1:0]         alpha_ff;
   logic [AGE_W-1:0]           timeout_ff;

   // held state
   logic signed [SAMPLE_W-1:0] held_yaw_ff, held_yaw_in;
   logic signed [SAMPLE_W-1:0] held_speed_ff, held_speed_in;
   logic signed [SAMPLE_W-1:0] filtered_ff, filtered_in;
   logic [CORNER_W-1:0]        held_corner_ff, held_corner_in;
   logic [AGE_W-1:0]           age_ff, age_in;
   logic                       data_valid_ff, data_valid_in;

   // input word latch and intermediates
   logic signed [SAMPLE_W-1:0] yaw_ff;
   logic signed [SAMPLE_W-1:0] spd_ff;
   logic [CORNER_W-1:0]        corner_ff;
   logic signed [SAMPLE_W-1:0] raw_ff;
   logic signed [MUL_A_W-1:0]  d_ff;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_fresh_ff;
   logic signed [SAMPLE_W-1:0] rsp_yaw_ff, rsp_ff_ff, rsp_spd_ff;
   logic [CORNER_W-1:0]        rsp_corner_ff;

   logic                       accept;
   logic                       out_free;
   logic                       out_load;

   logic                       mul_en;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;

   logic signed [PROD_W-1:0]   rnd1;
   logic signed [PROD_W-1:0]   raw_wide;
   logic signed [PROD_W-1:0]   lim_pos;
   logic signed [PROD_W-1:0]   raw_sel;
   logic signed [PROD_W-1:0]   rnd2;
   logic signed [PROD_W-1:0]   t_wide;
   logic signed [26:0]         sum27;
   logic signed [SAMPLE_W-1:0] filt_sat;
   logic signed [SAMPLE_W-1:0] yaw_new;
   logic [AGE_W-1:0]           age_inc;
   logic                       expire;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = out_free && (state_ff == S_DONE || state_ff == S_TICK);

   // shared multiplier: gain * speed first, then alpha * (y - raw)
   always_comb begin
      mul_en = (state_ff == S_MUL1) || (state_ff == S_MUL2);
      if (state_ff == S_MUL2) begin
         mul_a = d_ff;
         mul_b = $signed({1'b0, alpha_ff});
      end else begin
         mul_a = $signed({spd_ff[SAMPLE_W-1], spd_ff});
         mul_b = $signed({gain_ff[GAIN_W-1], gain_ff});
      end
   end

   ffs_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // round half up, then clamp to +/- limit
   always_comb begin
      rnd1     = prod + PROD_W'(128);
      raw_wide = rnd1 >>> 8;
      lim_pos  = $signed({{(PROD_W-LIMIT_W){1'b0}}, limit_ff});
      if (raw_wide > lim_pos) begin
         raw_sel = lim_pos;
      end else if (raw_wide < -lim_pos) begin
         raw_sel = -lim_pos;
      end else begin
         raw_sel = raw_wide;
      end
   end

   // filter finish: raw + round(alpha*d / 65536), saturated
   always_comb begin
      rnd2   = prod + PROD_W'(32768);
      t_wide = rnd2 >>> 16;
      sum27  = $signed({{3{raw_ff[SAMPLE_W-1]}}, raw_ff}) + t_wide[26:0];
      if (sum27[26:23] == 4'b0000 || sum27[26:23] == 4'b1111) begin
         filt_sat = sum27[SAMPLE_W-1:0];
      end else if (sum27[26]) begin
         filt_sat = SAMPLE_MIN;
      end else begin
         filt_sat = SAMPLE_MAX;
      end
      if (!negate_ff) begin
         yaw_new = yaw_ff;
      end else if (yaw_ff == SAMPLE_MIN) begin
         yaw_new = SAMPLE_MAX;
      end else begin
         yaw_new = -yaw_ff;
      end
      age_inc = (age_ff == {AGE_W{1'b1}}) ? age_ff : age_ff + AGE_W'(1);
      expire  = data_valid_ff && (age_inc > timeout_ff);
   end

   always_comb begin
      state_in       = state_ff;
      held_yaw_in    = held_yaw_ff;
      held_speed_in  = held_speed_ff;
      held_corner_in = held_corner_ff;
      filtered_in    = filtered_ff;
      age_in         = age_ff;
      data_valid_in  = data_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_operation == OP_TICK) ? S_TICK : S_MUL1;
            end
         end
         S_MUL1: state_in = S_RND;
         S_RND:  state_in = S_MUL2;
         S_MUL2: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               held_yaw_in    = yaw_new;
               held_speed_in  = spd_ff;
               held_corner_in = corner_ff;
               filtered_in    = data_valid_ff ? filt_sat : raw_ff;
               age_in         = '0;
               data_valid_in  = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               age_in = age_inc;
               if (expire) begin
                  data_valid_in = 1'b0;
                  filtered_in   = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         negate_ff      <= 1'b0;
         gain_ff        <= GAIN_RESET;
         limit_ff       <= LIMIT_RESET;
         alpha_ff       <= ALPHA_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         held_yaw_ff    <= '0;
         held_speed_ff  <= '0;
         filtered_ff    <= '0;
         held_corner_ff <= '0;
         age_ff         <= '0;
         data_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         held_yaw_ff    <= held_yaw_in;
         held_speed_ff  <= held_speed_in;
         filtered_ff    <= filtered_in;
         held_corner_ff <= held_corner_in;
         age_ff         <= age_in;
         data_valid_ff  <= data_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_YAW_NEGATE:    negate_ff  <= csr_wdata[0];
               REG_FF_GAIN:       gain_ff    <= $signed(csr_wdata[GAIN_W-1:0]);
               REG_FF_LIMIT:      limit_ff   <= csr_wdata[LIMIT_W-1:0];
               REG_LPF_ALPHA:     alpha_ff   <= csr_wdata[ALPHA_W-1:0];
               REG_TIMEOUT_TICKS: timeout_ff <= csr_wdata[AGE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         yaw_ff    <= req_yaw_rate;
         spd_ff    <= req_speed_diff;
         corner_ff <= req_corner_number;
      end
      if (state_ff == S_RND) begin
         raw_ff <= raw_sel[SAMPLE_W-1:0];
         d_ff   <= $signed({filtered_ff[SAMPLE_W-1], filtered_ff}) - raw_sel[MUL_A_W-1:0];
      end
      if (out_load) begin
         rsp_fresh_ff  <= data_valid_in;
         rsp_yaw_ff    <= data_valid_in ? held_yaw_in : '0;
         rsp_ff_ff     <= data_valid_in ? filtered_in : '0;
         rsp_spd_ff    <= held_speed_in;
         rsp_corner_ff <= held_corner_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fresh           = rsp_fresh_ff;
   assign rsp_yaw_rate_out    = rsp_yaw_ff;
   assign rsp_feedforward_out = rsp_ff_ff;
   assign rsp_speed_diff_out  = rsp_spd_ff;
   assign rsp_corner_out      = rsp_corner_ff;

`ifndef SYNTHESIS
   // a sample always leaves fresh, zero-aged data behind
   a_sample_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (data_valid_ff && age_ff == '0 && rsp_fresh))
      else $error("sample did not leave fresh state");

   // stale data carries no filter history
   a_invalid_clear: assert property (@(posedge clock) disable iff (reset)
      !data_valid_ff |-> (filtered_ff == '0))
      else $error("filter value kept while data invalid");

   // a pending fresh word reflects current valid state
   a_fresh_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fresh_ff) |-> data_valid_ff)
      else $error("fresh word pending while data invalid");

   // the shared multiplier works only in its two product steps; rounding follows the gain product
   a_mul_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> $past(state_ff == S_MUL1))
      else $error("rounding step without gain product");
`endif

endmodule
